// ----- rtl/pidfd_pkg.sv -----
// Package: shared constants and types for the filtered-derivative PID controller.
`default_nettype none
package pidfd_pkg;
    localparam int unsigned RegIdxW = 3;
    localparam logic [RegIdxW-1:0] REG_SETPOINT = 3'd0;
    localparam logic [RegIdxW-1:0] REG_GAIN_P   = 3'd1;
    localparam logic [RegIdxW-1:0] REG_GAIN_I   = 3'd2;
    localparam logic [RegIdxW-1:0] REG_GAIN_D   = 3'd3;
    localparam logic [RegIdxW-1:0] REG_OUT_LOW  = 3'd4;
    localparam logic [RegIdxW-1:0] REG_OUT_HIGH = 3'd5;
    localparam logic [RegIdxW-1:0] REG_COEF     = 3'd6;
    localparam logic [RegIdxW-1:0] REG_FLAGS    = 3'd7;
    localparam logic [16:0] COEF_ONE     = 17'd65536;
    localparam logic [16:0] COEF_DEFAULT = 17'd6554;

    typedef struct packed {
        logic        start;
        logic [32:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

// ----- rtl/pidfd_div.sv -----
// Serial restoring divider: signed 33-bit dividend by unsigned 32-bit divisor, truncated, saturated.
`default_nettype none
module pidfd_div
    import pidfd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_neg, n_neg;
    logic [32:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_dvs, n_dvs;
    logic        r_done, n_done;
    logic [33:0] trial;
    logic [33:0] qs;

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_neg  = r_neg;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_done = 1'b0;
        trial  = {r_rem, r_quo[32]} - {2'b00, r_dvs};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_neg  = i_req.dividend[32];
            n_quo  = i_req.dividend[32] ? (~i_req.dividend + 33'd1) : i_req.dividend;
            n_rem  = 33'd0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (!trial[33]) begin
                n_rem = trial[32:0];
                n_quo = {r_quo[31:0], 1'b1};
            end else begin
                n_rem = {r_rem[31:0], r_quo[32]};
                n_quo = {r_quo[31:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd32) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_neg <= n_neg;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    always_comb begin
        qs = r_neg ? (34'd0 - {1'b0, r_quo}) : {1'b0, r_quo};
        o_rsp.done = r_done;
        if (!qs[33] && qs[32:31] != 2'b00) begin
            o_rsp.quotient = 32'h7FFF_FFFF;
        end else if (qs[33] && qs[32:31] != 2'b11) begin
            o_rsp.quotient = 32'h8000_0000;
        end else begin
            o_rsp.quotient = qs[31:0];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/pid_controller_filtered_derivative.sv -----
// Top level: filtered-derivative PID controller with one shared multiplier and a serial divider.
//
//  channel | direction | handshake             | payload
//  in      | input     | i_in_valid/o_in_stall | measurement, now_tick, restart
//  out     | output    | o_out_valid/i_out_stall | control_out, error_now, derivative_now, updated
//  cfg     | input     | i_cfg_we              | i_cfg_index, i_cfg_data
//
// An updating item walks S_ERR, S_INT, S_INTS and S_DIV, where it waits on the
// 33-step serial divider, then S_FA and S_FB with the derivative filter on, then
// S_P, S_IH, S_IL, S_D, S_SUM and S_OUT; a held item shows its result after S_ERR.
// One 33x33 multiplier is shared by all products.
// Reset is synchronous and restores configuration, loop and handshake state. An output stall
// holds the result register; the next item is accepted the cycle after it leaves.
`default_nettype none
module pid_controller_filtered_derivative
    import pidfd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [31:0] i_measurement,
    input  wire logic [31:0]        i_now_tick,
    input  wire logic               i_restart,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_control_out,
    output logic signed [31:0]      o_error_now,
    output logic signed [31:0]      o_derivative_now,
    output logic                    o_updated,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    localparam logic [3:0] S_IDLE = 4'd0, S_ERR = 4'd1, S_INT = 4'd2, S_INTS = 4'd3,
        S_DIV = 4'd4, S_FA = 4'd5, S_FB = 4'd6, S_P = 4'd7, S_IH = 4'd8,
        S_IL = 4'd9, S_D = 4'd10, S_SUM = 4'd11, S_OUT = 4'd12;

    logic signed [31:0] r_setpoint, r_gain_p, r_gain_i, r_gain_d, r_out_low, r_out_high;
    logic [16:0] r_coef;
    logic [1:0]  r_flags;

    logic [3:0]  r_state;
    logic signed [47:0] r_integ;
    logic signed [31:0] r_prev_err, r_deriv, r_held;
    logic [31:0] r_last_tick;
    logic        r_first;

    logic signed [31:0] r_meas, r_err;
    logic [31:0] r_now, r_dt;
    logic signed [63:0] r_acc;
    logic signed [65:0] r_prod;
    logic signed [32:0] r_ma, r_mb;
    logic        r_mul_go;

    logic        r_ovalid;
    logic signed [31:0] r_o_ctl, r_o_err, r_o_der;
    logic        r_o_upd;

    t_div_req    div_req;
    t_div_rsp    div_rsp;

    logic in_acc;
    logic signed [32:0] err_w;
    logic signed [31:0] err_sat;
    logic [31:0] dt_w;
    logic signed [49:0] isum;
    logic signed [47:0] isat;
    logic signed [31:0] raw;
    logic [16:0] coef_eff;
    logic signed [47:0] fl16;
    logic signed [63:0] fsum;
    logic signed [31:0] osat;
    logic signed [31:0] oclamp;
    logic signed [47:0] iclamp;
    logic signed [48:0] prod_sat;

    function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
        input logic signed [31:0] lo, input logic signed [31:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_ovalid;
    assign err_w      = {r_setpoint[31], r_setpoint} - {r_meas[31], r_meas};
    assign err_sat    = (err_w[32] != err_w[31]) ? {err_w[32], {31{~err_w[32]}}} : err_w[31:0];
    assign dt_w       = r_now - r_last_tick;
    assign raw        = div_rsp.quotient;
    assign coef_eff   = (r_coef == 17'd0) ? COEF_DEFAULT : (r_coef > COEF_ONE ? COEF_ONE : r_coef);
    assign fl16       = r_prod[63:16];
    assign fsum       = r_acc + r_prod[63:0];
    assign prod_sat   = (r_prod > 66'sh7FFF_FFFF_FFFF) ? 49'sh7FFF_FFFF_FFFF :
                        (r_prod < -66'sh8000_0000_0000) ? -49'sh8000_0000_0000 : r_prod[48:0];
    assign isum       = {{2{r_integ[47]}}, r_integ} + {prod_sat[48], prod_sat};
    assign isat       = (isum > 50'sh7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF :
                        (isum < -50'sh8000_0000_0000) ? -48'sh8000_0000_0000 : isum[47:0];
    assign iclamp     = (isat < 48'(r_out_low)) ? 48'(r_out_low) :
                        (isat > 48'(r_out_high)) ? 48'(r_out_high) : isat;
    assign osat       = (r_acc > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                        (r_acc < -64'sh8000_0000) ? -32'sh8000_0000 : r_acc[31:0];
    assign oclamp     = clamp32(osat, r_out_low, r_out_high);

    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= '0; r_gain_p <= '0; r_gain_i <= '0; r_gain_d <= '0;
            r_out_low <= 32'sh8000_0000; r_out_high <= 32'sh7FFF_FFFF;
            r_coef <= COEF_DEFAULT; r_flags <= 2'b11;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SETPOINT: r_setpoint <= i_cfg_data;
                REG_GAIN_P:   r_gain_p   <= i_cfg_data;
                REG_GAIN_I:   r_gain_i   <= i_cfg_data;
                REG_GAIN_D:   r_gain_d   <= i_cfg_data;
                REG_OUT_LOW:  r_out_low  <= i_cfg_data;
                REG_OUT_HIGH: r_out_high <= i_cfg_data;
                REG_COEF:     r_coef     <= i_cfg_data[16:0];
                REG_FLAGS:    r_flags    <= i_cfg_data[1:0];
                default:      r_flags    <= r_flags;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ovalid <= 1'b0;
            r_integ <= '0; r_prev_err <= '0; r_deriv <= '0; r_held <= '0;
            r_last_tick <= '0; r_first <= 1'b1;
            r_mul_go <= 1'b0;
            div_req.start <= 1'b0;
        end else begin
            div_req.start <= (r_state == S_ERR) && !r_first && (dt_w != 32'd0);
            if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_meas <= i_measurement;
                        r_now  <= i_now_tick;
                        if (i_restart) begin
                            r_integ <= '0; r_prev_err <= '0; r_deriv <= '0; r_held <= '0;
                            r_last_tick <= '0; r_first <= 1'b1;
                        end
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_err <= err_sat;
                    r_dt  <= dt_w;
                    if (r_first || dt_w == 32'd0) begin
                        if (r_first) begin
                            r_last_tick <= r_now; r_prev_err <= err_sat; r_first <= 1'b0;
                        end
                        r_o_ctl <= r_held; r_o_err <= err_sat; r_o_der <= r_deriv;
                        r_o_upd <= 1'b0; r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_ma <= {err_sat[31], err_sat};
                        r_mb <= {1'b0, dt_w};
                        div_req.dividend <= {err_sat[31], err_sat} - {r_prev_err[31], r_prev_err};
                        div_req.divisor  <= dt_w;
                        r_state <= S_INT;
                    end
                end
                S_INT: r_state <= S_INTS;
                S_INTS: begin
                    r_integ <= r_flags[0] ? iclamp : isat;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        if (r_flags[1]) begin
                            r_ma <= 33'(COEF_ONE - coef_eff);
                            r_mb <= {r_deriv[31], r_deriv};
                            r_acc <= '0;
                            r_dt <= raw;
                            r_state <= S_FA;
                        end else begin
                            r_deriv <= raw;
                            r_ma <= {r_gain_p[31], r_gain_p};
                            r_mb <= {r_err[31], r_err};
                            r_state <= S_P;
                        end
                    end
                end
                S_FA: begin
                    r_ma <= 33'(coef_eff);
                    r_mb <= {r_dt[31], r_dt};
                    r_state <= S_FB;
                end
                S_FB: begin
                    if (r_acc == '0 && !r_mul_go) begin
                        r_acc <= r_prod[63:0];
                        r_mul_go <= 1'b1;
                    end else begin
                        r_deriv <= fsum[47:16];
                        r_mul_go <= 1'b0;
                        r_ma <= {r_gain_p[31], r_gain_p};
                        r_mb <= {r_err[31], r_err};
                        r_state <= S_P;
                    end
                end
                S_P: begin
                    r_ma <= {r_gain_i[31], r_gain_i};
                    r_mb <= {r_integ[47], r_integ[47:16]};
                    r_state <= S_IH;
                end
                S_IH: begin
                    r_acc <= 64'(fl16);
                    r_ma <= {r_gain_i[31], r_gain_i};
                    r_mb <= {17'd0, r_integ[15:0]};
                    r_state <= S_IL;
                end
                S_IL: begin
                    r_acc <= r_acc + r_prod[63:0];
                    r_ma <= {r_gain_d[31], r_gain_d};
                    r_mb <= {r_deriv[31], r_deriv};
                    r_state <= S_D;
                end
                S_D: begin
                    r_acc <= r_acc + 64'(fl16);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_acc <= r_acc + 64'(fl16);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_held <= oclamp;
                    r_prev_err <= r_err;
                    r_last_tick <= r_now;
                    r_o_ctl <= oclamp; r_o_err <= r_err; r_o_der <= r_deriv;
                    r_o_upd <= 1'b1; r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    pidfd_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign o_out_valid      = r_ovalid;
    assign o_control_out    = r_o_ctl;
    assign o_error_now      = r_o_err;
    assign o_derivative_now = r_o_der;
    assign o_updated        = r_o_upd;

`ifndef SYNTHESIS
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall) else $error("item taken while busy");
    a_first_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERR && r_first) |=> (o_out_valid && !o_updated))
        else $error("first item updated output");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV)) else $error("divider done out of step");
`endif
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for the filtered-derivative PID controller: directed table plus random control loops.
`timescale 1ns / 1ps
module tb_top
    import pidfd_pkg::*;
();

    typedef struct packed {
        logic signed [31:0] ctrl;
        logic signed [31:0] err;
        logic signed [31:0] deriv;
        logic               upd;
    } t_result;

    typedef struct {
        logic [31:0] meas;
        logic [31:0] tick;
        logic        restart;
        logic        typed;
        t_result     res;
    } t_row;

    localparam longint SAT48_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SAT48_LO = -64'sh0000_8000_0000_0000;
    localparam longint SAT32_HI = 64'sd2147483647;
    localparam longint SAT32_LO = -64'sd2147483648;

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic signed [31:0] in_meas;
    logic [31:0]        in_tick;
    logic               in_restart;
    logic               out_stall;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [31:0] o_control_out;
    logic signed [31:0] o_error_now;
    logic signed [31:0] o_derivative_now;
    logic               o_updated;

    pid_controller_filtered_derivative dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_measurement    (in_meas),
        .i_now_tick       (in_tick),
        .i_restart        (in_restart),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_control_out    (o_control_out),
        .o_error_now      (o_error_now),
        .o_derivative_now (o_derivative_now),
        .o_updated        (o_updated),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    // controller model state
    logic [31:0] ctl_reg [8];
    longint      integ_acc;
    longint      last_err;
    longint      deriv_acc;
    logic [31:0] last_tick;
    logic        first_pending;
    longint      held_out;

    t_result     pending_results[$];
    int          n_mismatch;
    int          n_items;
    int          n_updates;
    int          n_restarts;
    bit          calm;
    bit          hold_req;
    logic [31:0] tick_now;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint sx32(logic [31:0] x);
        return longint'(signed'(x));
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint clamp_out(longint v);
        if (v < sx32(ctl_reg[REG_OUT_LOW])) return sx32(ctl_reg[REG_OUT_LOW]);
        if (v > sx32(ctl_reg[REG_OUT_HIGH])) return sx32(ctl_reg[REG_OUT_HIGH]);
        return v;
    endfunction

    function automatic longint mul_floor16(longint g, longint a);
        logic signed [95:0] prod;
        prod = g * a;
        return longint'(prod >>> 16);
    endfunction

    task automatic clear_loop_state();
        integ_acc     = 0;
        last_err      = 0;
        deriv_acc     = 0;
        last_tick     = '0;
        first_pending = 1'b1;
        held_out      = 0;
    endtask

    task automatic pid_predict(input logic [31:0] meas, input logic [31:0] tick,
                               input logic restart, output t_result r);
        longint      err;
        longint      dt;
        longint      raw;
        longint      c;
        longint      sum;
        logic [31:0] dtu;
        logic        upd;
        upd = 1'b0;
        if (restart) clear_loop_state();
        err = sat(sx32(ctl_reg[REG_SETPOINT]) - sx32(meas), SAT32_LO, SAT32_HI);
        if (first_pending) begin
            last_tick     = tick;
            last_err      = err;
            first_pending = 1'b0;
        end else begin
            dtu = tick - last_tick;
            if (dtu != 0) begin
                dt = longint'({32'b0, dtu});
                integ_acc = sat(integ_acc + sat(err * dt, SAT48_LO, SAT48_HI),
                                SAT48_LO, SAT48_HI);
                if (ctl_reg[REG_FLAGS][0]) integ_acc = clamp_out(integ_acc);
                raw = sat((err - last_err) / dt, SAT32_LO, SAT32_HI);
                if (ctl_reg[REG_FLAGS][1]) begin
                    c = longint'(ctl_reg[REG_COEF][16:0]);
                    if (c > longint'(COEF_ONE)) c = longint'(COEF_ONE);
                    if (c == 0) c = longint'(COEF_DEFAULT);
                    deriv_acc = ((longint'(COEF_ONE) - c) * deriv_acc + c * raw) >>> 16;
                end else begin
                    deriv_acc = raw;
                end
                sum = mul_floor16(sx32(ctl_reg[REG_GAIN_P]), err)
                    + mul_floor16(sx32(ctl_reg[REG_GAIN_I]), integ_acc)
                    + mul_floor16(sx32(ctl_reg[REG_GAIN_D]), deriv_acc);
                held_out  = clamp_out(sat(sum, SAT32_LO, SAT32_HI));
                last_err  = err;
                last_tick = tick;
                upd       = 1'b1;
            end
        end
        r.ctrl  = held_out[31:0];
        r.err   = err[31:0];
        r.deriv = deriv_acc[31:0];
        r.upd   = upd;
    endtask

    task automatic report(input string field, input longint got, input longint want);
        n_mismatch++;
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_control_out !== want.ctrl) report("control_out", o_control_out, want.ctrl);
                if (o_error_now !== want.err) report("error_now", o_error_now, want.err);
                if (o_derivative_now !== want.deriv)
                    report("derivative_now", o_derivative_now, want.deriv);
                if (o_updated !== want.upd) report("updated", o_updated, want.upd);
            end
        end
    end

    // output side: random stall before each item, one long hold on request
    initial begin
        int n;
        out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (400) @(negedge i_clk) out_stall <= 1'b1;
            end
            n = calm ? 0 : $urandom_range(0, 11);
            repeat (n) @(negedge i_clk) out_stall <= 1'b1;
            @(negedge i_clk) out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_item(input logic [31:0] meas, input logic [31:0] tick,
                             input logic restart, input logic typed, input t_result typed_res);
        int      gap;
        t_result r;
        gap = calm ? 0 : $urandom_range(0, 11);
        repeat (gap) @(negedge i_clk) in_valid <= 1'b0;
        @(negedge i_clk);
        in_valid   <= 1'b1;
        in_meas    <= meas;
        in_tick    <= tick;
        in_restart <= restart;
        do @(posedge i_clk); while (o_in_stall);
        pid_predict(meas, tick, restart, r);
        pending_results.push_back(typed ? typed_res : r);
        n_items++;
        n_updates  += r.upd;
        n_restarts += restart;
    endtask

    task automatic drain();
        @(negedge i_clk) in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk) cfg_we <= 1'b0;
        case (idx)
            REG_COEF:  ctl_reg[idx] = {15'b0, data[16:0]};
            REG_FLAGS: ctl_reg[idx] = {30'b0, data[1:0]};
            default:   ctl_reg[idx] = data;
        endcase
    endtask

    function automatic logic [31:0] rand_meas();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45) return ctl_reg[REG_SETPOINT] + 32'($signed($urandom_range(0, 8192)) - 4096);
        if (sel < 50) return (sel < 48) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if (sel < 75) return ctl_reg[REG_SETPOINT] + 32'($signed($urandom_range(0, 2097152)) - 1048576);
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_step();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8) return 32'd0;
        if (sel < 85) return $urandom_range(1, 16);
        if (sel < 93) return $urandom_range(17, 100000);
        return $urandom;
    endfunction

    t_row directed[8];
    logic [31:0] phase_cfg[5][8];

    initial begin
        t_result none;
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_meas    = '0;
        in_tick    = '0;
        in_restart = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_SETPOINT;
        cfg_data   = '0;
        n_mismatch = 0;
        n_items    = 0;
        n_updates  = 0;
        n_restarts = 0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        none       = '0;
        ctl_reg[REG_SETPOINT] = 32'h0;
        ctl_reg[REG_GAIN_P]   = 32'h0;
        ctl_reg[REG_GAIN_I]   = 32'h0;
        ctl_reg[REG_GAIN_D]   = 32'h0;
        ctl_reg[REG_OUT_LOW]  = 32'h8000_0000;
        ctl_reg[REG_OUT_HIGH] = 32'h7FFF_FFFF;
        ctl_reg[REG_COEF]     = 32'(COEF_DEFAULT);
        ctl_reg[REG_FLAGS]    = 32'd3;
        clear_loop_state();

        directed[0] = '{32'h0000_1000, 32'd100, 1'b0, 1'b1, '{32'd0, -32'sh1000, 32'd0, 1'b0}};
        directed[1] = '{32'h0000_1000, 32'd100, 1'b0, 1'b1, '{32'd0, -32'sh1000, 32'd0, 1'b0}};
        directed[2] = '{32'h8000_0000, 32'd101, 1'b0, 1'b0, none};
        directed[3] = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, none};
        directed[4] = '{32'h0000_0000, 32'd5, 1'b0, 1'b0, none};
        directed[5] = '{32'h0001_2345, 32'd5, 1'b1, 1'b1, '{32'd0, -32'sh12345, 32'd0, 1'b0}};
        directed[6] = '{32'hFFFF_0000, 32'd6, 1'b0, 1'b0, none};
        directed[7] = '{32'h0000_0000, 32'h8000_0006, 1'b0, 1'b0, none};

        phase_cfg[0] = '{32'h0001_0000, 32'h0002_0000, 32'h0000_0800, 32'h0000_4000,
                         32'hFFF0_0000, 32'h0010_0000, 32'd6554, 32'd3};
        phase_cfg[1] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h7FFF_FFFF, 32'd65536, 32'd1};
        phase_cfg[2] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd2};
        phase_cfg[3] = '{32'h0000_0000, 32'h0001_0000, 32'h0000_0100, 32'h0001_0000,
                         32'h0005_0000, 32'hFFFB_0000, 32'h0001_FFFF, 32'd3};
        phase_cfg[4] = '{32'hFFFF_8000, 32'h0000_C000, 32'h0000_0040, 32'h0003_0000,
                         32'hFFFE_0000, 32'h0002_0000, 32'd1, 32'd0};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (directed[k])
            send_item(directed[k].meas, directed[k].tick, directed[k].restart,
                      directed[k].typed, directed[k].res);
        drain();

        tick_now = $urandom;
        for (int ph = 0; ph < 8; ph++) begin
            for (int k = 0; k < 8; k++)
                write_reg(k[2:0], (ph < 5) ? phase_cfg[ph][k] :
                          (k == REG_COEF) ? 32'($urandom_range(0, 131071)) :
                          (k == REG_FLAGS) ? 32'($urandom_range(0, 3)) : $urandom);
            calm = (ph % 3 == 1);
            for (int n = 0; n < 155; n++) begin
                logic rs;
                if (ph == 2 && n == 40) hold_req = 1'b1;
                rs = ($urandom_range(0, 99) < 3);
                tick_now = tick_now + rand_step();
                send_item(rand_meas(), tick_now, rs, 1'b0, none);
            end
            drain();
        end

        $display("sent %0d items: %0d updates, %0d restarts, 9 register settings",
                 n_items, n_updates, n_restarts);
        $display("covered saturated errors, tick wrap, crossed limits, coefficient edge cases");
        if (n_mismatch == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
